FILE: rtl/gtc_pkg.sv
// gtc_pkg: shared types, constants and helpers of the glyph text console
// used by every module of the block; depends on nothing
`default_nettype none

package gtc_pkg;

  localparam int GLYPH_WIDTH       = 6;
  localparam int GLYPH_HEIGHT      = 10;
  localparam int GLYPH_STORE_BYTES = 2048;

  localparam int GLYPH_BITS = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int GS_AW      = $clog2(GLYPH_STORE_BYTES);
  localparam int BIT_W      = $clog2(256 * GLYPH_BITS);
  localparam int GX_W       = $clog2(GLYPH_WIDTH);
  localparam int GY_W       = $clog2(GLYPH_HEIGHT);
  localparam int PX_W       = $clog2(512 * GLYPH_WIDTH);
  localparam int PY_W       = $clog2(256 * GLYPH_HEIGHT);

  localparam int ADDR_W  = 22;
  localparam int COLOR_W = 24;
  localparam int FW_W    = 12;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;

  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_GLYPH  = 2'd1;
  localparam logic [1:0] OP_CURSOR = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] REQ_PIXEL  = 2'd0;
  localparam logic [1:0] REQ_SCROLL = 2'd1;
  localparam logic [1:0] REQ_FILL   = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS  = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] glyph_byte_index;
    logic [7:0]  glyph_byte_value;
    logic [8:0]  new_column;
    logic [7:0]  new_row;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         request_kind;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_value;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic               color_mode;
    logic [COLOR_W-1:0] foreground_color;
    logic [COLOR_W-1:0] background_color;
    logic [FW_W-1:0]    frame_width;
    logic [COL_W-1:0]   text_columns;
    logic [ROW_W-1:0]   text_rows;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_GLYPH,
    CMD_DRAW,
    CMD_FILL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              draw;
    logic              scroll;
    logic [7:0]        char_code;
    logic [PY_W-1:0]   py0;
    logic [PX_W-1:0]   px0;
    logic [10:0]       glyph_index;
    logic [7:0]        glyph_value;
  } cmd_t;

  function automatic logic [COLOR_W-1:0] format_color(input logic mode,
                                                      input logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] r;
    if (mode) begin
      r = {8'd0, c[23:19], c[15:10], c[7:3]};
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gtc_cmd_fifo.sv
// gtc_cmd_fifo: short command queue between the front and the back
// depends on gtc_pkg for the command type and depth
`default_nettype none

module gtc_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  gtc_pkg::cmd_t      push_data,
  output logic               full,
  input  wire logic          pop,
  output gtc_pkg::cmd_t      pop_data,
  output logic               empty
);

  gtc_pkg::cmd_t q_r [gtc_pkg::CMD_DEPTH];
  logic [gtc_pkg::CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [gtc_pkg::CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full     = (cnt_r == gtc_pkg::CMD_CNT_W'(gtc_pkg::CMD_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gtc_front.sv
// gtc_front: accepts input items, keeps the text cursor, queues draw, glyph and fill commands
// depends on gtc_pkg
`default_nettype none

module gtc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  gtc_pkg::cfg_t      cfg,
  input  wire logic          in_push,
  input  gtc_pkg::in_item_t  in_data,
  output logic               in_full,
  output logic               cmd_push,
  output gtc_pkg::cmd_t      cmd_data,
  input  wire logic          cmd_full
);

  logic [gtc_pkg::COL_W-1:0] col_r, col_nxt;
  logic [gtc_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [gtc_pkg::COL_W:0]   col_a;
  logic [gtc_pkg::ROW_W:0]   row_a;
  logic accept, want, draw, scroll;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;
  assign cmd_push = accept && want;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    want    = 1'b0;
    draw    = 1'b0;
    scroll  = 1'b0;
    col_a   = {1'b0, col_r};
    row_a   = {1'b0, row_r};
    cmd_data.kind        = gtc_pkg::CMD_DRAW;
    cmd_data.char_code   = in_data.char_code;
    cmd_data.py0         = gtc_pkg::PY_W'(gtc_pkg::GLYPH_HEIGHT * row_r);
    cmd_data.px0         = gtc_pkg::PX_W'(gtc_pkg::GLYPH_WIDTH * col_r);
    cmd_data.glyph_index = in_data.glyph_byte_index;
    cmd_data.glyph_value = in_data.glyph_byte_value;
    unique case (in_data.operation)
      gtc_pkg::OP_PUT: begin
        if (in_data.char_code == gtc_pkg::CHAR_CR) begin
          col_a = '0;
        end else if (in_data.char_code == gtc_pkg::CHAR_LF) begin
          col_a = '0;
          row_a = row_a + 1'b1;
        end else begin
          col_a = col_a + 1'b1;
          draw  = 1'b1;
        end
        if (col_a >= {1'b0, cfg.text_columns}) begin
          col_a = '0;
          row_a = row_a + 1'b1;
        end
        if (row_a >= {1'b0, cfg.text_rows}) begin
          scroll = 1'b1;
          row_a  = (cfg.text_rows == '0) ? '0 : {1'b0, cfg.text_rows - 1'b1};
        end
        want = draw || scroll;
        if (accept) begin
          col_nxt = col_a[gtc_pkg::COL_W-1:0];
          row_nxt = row_a[gtc_pkg::ROW_W-1:0];
        end
      end
      gtc_pkg::OP_GLYPH: begin
        cmd_data.kind = gtc_pkg::CMD_GLYPH;
        want = 1'b1;
      end
      gtc_pkg::OP_CURSOR: begin
        if (accept) begin
          if (cfg.text_columns == '0) begin
            col_nxt = '0;
          end else if (in_data.new_column >= cfg.text_columns) begin
            col_nxt = cfg.text_columns - 1'b1;
          end else begin
            col_nxt = in_data.new_column;
          end
          if (cfg.text_rows == '0) begin
            row_nxt = '0;
          end else if (in_data.new_row >= cfg.text_rows) begin
            row_nxt = cfg.text_rows - 1'b1;
          end else begin
            row_nxt = in_data.new_row;
          end
        end
      end
      gtc_pkg::OP_CLEAR: begin
        cmd_data.kind = gtc_pkg::CMD_FILL;
        want = 1'b1;
        if (accept) begin
          col_nxt = '0;
          row_nxt = '0;
        end
      end
      default: begin
        want = 1'b0;
      end
    endcase
    cmd_data.draw   = draw;
    cmd_data.scroll = scroll;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gtc_back.sv
// gtc_back: glyph store, pixel sequencer and result queue
// depends on gtc_pkg; fed from gtc_cmd_fifo
`default_nettype none

module gtc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  gtc_pkg::cfg_t      cfg,
  input  gtc_pkg::cmd_t      cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output gtc_pkg::out_item_t out_data
);

  localparam int PROD_W = gtc_pkg::PY_W + gtc_pkg::FW_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX,
    ST_SCROLL
  } state_t;

  state_t state_r, state_nxt;
  logic [gtc_pkg::BIT_W-1:0]  bit_r, bit_nxt;
  logic [gtc_pkg::GX_W-1:0]   sx_r, sx_nxt;
  logic [gtc_pkg::GY_W-1:0]   sy_r, sy_nxt;
  logic [gtc_pkg::ADDR_W-1:0] line_r, line_nxt, pix_r, pix_nxt, start_addr;
  logic                       scroll_r, scroll_nxt;
  logic [PROD_W-1:0]          prod;

  logic [7:0] mem [gtc_pkg::GLYPH_STORE_BYTES];
  logic [7:0] rd_data_r;
  logic [gtc_pkg::GS_AW-1:0] rd_addr;
  logic mem_we;

  logic                       iss_v, iss_last;
  logic [1:0]                 iss_kind;
  logic [gtc_pkg::ADDR_W-1:0] iss_addr;
  logic                       s1_v_r, s1_last_r;
  logic [1:0]                 s1_kind_r;
  logic [gtc_pkg::ADDR_W-1:0] s1_addr_r;
  logic [2:0]                 s1_bsel_r;

  gtc_pkg::out_item_t q_r [gtc_pkg::OUT_DEPTH];
  gtc_pkg::out_item_t push_item;
  logic [gtc_pkg::OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [gtc_pkg::OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic can_issue, do_pop;
  logic [gtc_pkg::COLOR_W-1:0] fg_f, bg_f;

  assign prod = PROD_W'(cmd.py0) * PROD_W'(cfg.frame_width);
  assign start_addr = prod[gtc_pkg::ADDR_W-1:0] + gtc_pkg::ADDR_W'(cmd.px0);
  assign can_issue = (cnt_r + gtc_pkg::OUT_CNT_W'(s1_v_r))
                     < gtc_pkg::OUT_CNT_W'(gtc_pkg::OUT_DEPTH);

  always_comb begin
    state_nxt  = state_r;
    bit_nxt    = bit_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    line_nxt   = line_r;
    pix_nxt    = pix_r;
    scroll_nxt = scroll_r;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    iss_v      = 1'b0;
    iss_kind   = gtc_pkg::REQ_PIXEL;
    iss_addr   = pix_r;
    iss_last   = 1'b0;
    rd_addr    = gtc_pkg::GS_AW'(bit_r >> 3);
    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd.kind)
            gtc_pkg::CMD_GLYPH: begin
              cmd_pop = 1'b1;
              mem_we  = 1'b1;
            end
            gtc_pkg::CMD_FILL: begin
              if (can_issue) begin
                cmd_pop  = 1'b1;
                iss_v    = 1'b1;
                iss_kind = gtc_pkg::REQ_FILL;
                iss_addr = '0;
                iss_last = 1'b1;
              end
            end
            gtc_pkg::CMD_DRAW: begin
              if (can_issue) begin
                cmd_pop    = 1'b1;
                scroll_nxt = cmd.scroll;
                if (cmd.draw) begin
                  bit_nxt   = gtc_pkg::BIT_W'(gtc_pkg::GLYPH_BITS * cmd.char_code);
                  sx_nxt    = '0;
                  sy_nxt    = '0;
                  line_nxt  = start_addr;
                  pix_nxt   = start_addr;
                  state_nxt = ST_PIX;
                end else begin
                  state_nxt = ST_SCROLL;
                end
              end
            end
            default: begin
              cmd_pop = 1'b0;
            end
          endcase
        end
      end
      ST_PIX: begin
        if (can_issue) begin
          iss_v   = 1'b1;
          bit_nxt = bit_r + 1'b1;
          if (sx_r == gtc_pkg::GX_W'(gtc_pkg::GLYPH_WIDTH - 1)) begin
            sx_nxt   = '0;
            line_nxt = line_r + gtc_pkg::ADDR_W'(cfg.frame_width);
            pix_nxt  = line_r + gtc_pkg::ADDR_W'(cfg.frame_width);
            if (sy_r == gtc_pkg::GY_W'(gtc_pkg::GLYPH_HEIGHT - 1)) begin
              iss_last  = !scroll_r;
              state_nxt = scroll_r ? ST_SCROLL : ST_IDLE;
            end else begin
              sy_nxt = sy_r + 1'b1;
            end
          end else begin
            sx_nxt  = sx_r + 1'b1;
            pix_nxt = pix_r + 1'b1;
          end
        end
      end
      ST_SCROLL: begin
        if (can_issue) begin
          iss_v     = 1'b1;
          iss_kind  = gtc_pkg::REQ_SCROLL;
          iss_addr  = '0;
          iss_last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      s1_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= iss_v;
    end
    bit_r     <= bit_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    line_r    <= line_nxt;
    pix_r     <= pix_nxt;
    scroll_r  <= scroll_nxt;
    s1_kind_r <= iss_kind;
    s1_addr_r <= iss_addr;
    s1_last_r <= iss_last;
    s1_bsel_r <= bit_r[2:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[gtc_pkg::GS_AW'(cmd.glyph_index)] <= cmd.glyph_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // result formatting and queue
  assign fg_f = gtc_pkg::format_color(cfg.color_mode, cfg.foreground_color);
  assign bg_f = gtc_pkg::format_color(cfg.color_mode, cfg.background_color);

  always_comb begin
    push_item.request_kind  = s1_kind_r;
    push_item.pixel_address = s1_addr_r;
    push_item.last_of_run   = s1_last_r;
    if (s1_kind_r == gtc_pkg::REQ_PIXEL && rd_data_r[s1_bsel_r]) begin
      push_item.pixel_value = fg_f;
    end else begin
      push_item.pixel_value = bg_f;
    end
  end

  assign out_empty = (cnt_r == '0);
  assign do_pop    = out_pop && !out_empty;
  assign out_data  = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (s1_v_r && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !s1_v_r) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_v_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/glyph_text_console_unit.sv
// glyph_text_console_unit: top level of the bitmap font text console
// holds the configuration registers; built from gtc_front, gtc_cmd_fifo and gtc_back
//
// Input items are pushed with in_push while in_full is low. Results leave as a
// queue: while out_empty is low the oldest result sits on out_data and out_pop
// takes it. Registers are written through cfg_we/cfg_index/cfg_data, one per cycle.
// The user must write them only while the block is idle; it is not enforced.
// A printable character gives one pixel write per glyph bit (60 for a 6x10 glyph)
// plus an optional scroll request; the back end issues one result per cycle while the
// result queue has room, for a character after a command pop: one per glyph bit, then
// the scroll request. A pixel write reaches out_data through the command queue, the
// command pop, the glyph store read and the result queue; a fill request through the
// command queue, the issue register and the result queue. Clear and a scroll-only line
// break give one result; glyph writes and cursor moves give none.
// Items queue in a four-entry command queue, so the front keeps accepting while
// the back end draws; when the receiver stalls the result queue fills, the back
// end holds, and in_full rises once the command queue is full.
// Reset homes the cursor, loads the register defaults and empties both queues;
// the glyph store is not cleared and must be written before use.
`default_nettype none

module glyph_text_console_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  input  gtc_pkg::in_item_t                     in_data,
  output logic                                  in_full,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output gtc_pkg::out_item_t                    out_data,
  input  wire logic                             cfg_we,
  input  wire logic [gtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gtc_pkg::CFG_W-1:0]        cfg_data
);

  gtc_pkg::cfg_t cfg_r;
  gtc_pkg::cmd_t front_cmd, back_cmd;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_mode       <= 1'b0;
      cfg_r.foreground_color <= 24'hFFFFFF;
      cfg_r.background_color <= 24'h000000;
      cfg_r.frame_width      <= 12'd320;
      cfg_r.text_columns     <= 9'd53;
      cfg_r.text_rows        <= 8'd48;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gtc_pkg::REG_COLOR_MODE: cfg_r.color_mode       <= cfg_data[0];
        gtc_pkg::REG_FG_COLOR:   cfg_r.foreground_color <= cfg_data;
        gtc_pkg::REG_BG_COLOR:   cfg_r.background_color <= cfg_data;
        gtc_pkg::REG_FRAME_W:    cfg_r.frame_width      <= cfg_data[gtc_pkg::FW_W-1:0];
        gtc_pkg::REG_TEXT_COLS:  cfg_r.text_columns     <= cfg_data[gtc_pkg::COL_W-1:0];
        gtc_pkg::REG_TEXT_ROWS:  cfg_r.text_rows        <= cfg_data[gtc_pkg::ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gtc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_data (front_cmd),
    .cmd_full (cmd_full)
  );

  gtc_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (front_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (back_cmd),
    .empty     (cmd_empty)
  );

  gtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_request_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.request_kind != gtc_pkg::REQ_PIXEL
      |-> out_data.last_of_run && out_data.pixel_address == '0)
    else $error("scroll or fill request not closing its run");

  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.request_kind == gtc_pkg::REQ_PIXEL
                || out_data.request_kind == gtc_pkg::REQ_SCROLL
                || out_data.request_kind == gtc_pkg::REQ_FILL)
    else $error("unknown request kind");
`endif

endmodule

`default_nettype wire
